### rtl/alarm_pkg.sv
// ----------------------------------------------------------------------------
// Alarm slot scheduler package
// Shared types, codes and constants for the alarm slot scheduler.
// ----------------------------------------------------------------------------
package alarm_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam logic [15:0] RING_DUR_RST = 16'd180;
  localparam logic [15:0] TPM_RST = 16'd60;
  localparam logic [7:0] DEFAULT_SNOOZE = 8'd5;
  localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;
  localparam logic signed [17:0] FAR_DELTA = 18'sd100000;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_UPDATE = 3'd1,
    OP_DISMISS = 3'd2,
    OP_SNOOZE = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_RING = 3'd1,
    EV_SNOOZE = 3'd2,
    EV_DISMISS = 3'd3,
    EV_CANCEL = 3'd4,
    EV_RERING = 3'd5,
    EV_WRITTEN = 3'd6
  } ev_t;

  localparam logic [0:0] REG_RING_DUR = 1'b0;
  localparam logic [0:0] REG_TPM = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DECIDE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic mul;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] slot;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [6:0] days_mask;
    logic       repeat_flag;
    logic       enable_flag;
    logic [7:0] snooze_minutes;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [2:0] now_weekday;
    logic       time_valid;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       ringing;
    logic       snoozing;
    logic [3:0] active_slot;
    logic [7:0] snooze_length_min;
    logic       next_valid;
    logic [4:0] next_hour;
    logic [5:0] next_minute;
  } out_word_t;

endpackage

### rtl/alarm_if.sv
// ----------------------------------------------------------------------------
// Alarm stream interface
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface alarm_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### rtl/alarm_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm controller
// Sequences the slot scan, snooze multiply and decision stages.
// ----------------------------------------------------------------------------
module alarm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  alarm_pkg::stat_t   stat,
  output alarm_pkg::cmd_t    cmd
);

  alarm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alarm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      alarm_pkg::ST_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = alarm_pkg::ST_SCAN;
        end
      end
      alarm_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = alarm_pkg::ST_MUL;
        end
      end
      alarm_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = alarm_pkg::ST_DECIDE;
      end
      alarm_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = alarm_pkg::ST_IDLE;
      end
      default: begin
        state_next = alarm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/alarm_dp.sv
// ----------------------------------------------------------------------------
// Alarm datapath
// Slot table, per-slot scan for matches and next alarm, cycle timers.
// ----------------------------------------------------------------------------
module alarm_dp #(
  parameter int SLOT_COUNT = alarm_pkg::SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  alarm_pkg::cmd_t      cmd,
  output alarm_pkg::stat_t     stat,
  input  alarm_pkg::in_word_t  in_word,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output alarm_pkg::out_word_t out_word,
  output logic                 out_valid,
  input  logic                 out_ready
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [4:0] t_hour [SLOT_COUNT];
  logic [5:0] t_min [SLOT_COUNT];
  logic [6:0] t_days [SLOT_COUNT];
  logic       t_rep [SLOT_COUNT];
  logic       t_en [SLOT_COUNT];
  logic [7:0] t_snz [SLOT_COUNT];

  logic [15:0] ring_dur, tpm;
  alarm_pkg::in_word_t iw;
  logic [CW-1:0] idx;
  logic [IW-1:0] sidx;
  logic last_valid;
  logic [10:0] last_min;
  logic ring_active, snooze_active, snooze_spent, cycle_valid;
  logic [IW-1:0] cycle_slot;
  logic [15:0] ring_elapsed;
  logic [23:0] snooze_elapsed, snooze_target;
  logic found;
  logic [IW-1:0] first;
  logic signed [17:0] best;
  logic nv;
  logic [4:0] nxh;
  logic [5:0] nxm;
  logic [7:0] snz_min;
  logic [23:0] snz_prod;
  logic check;

  logic [10:0] now_total, am;
  logic [6:0] today;
  logic match, qok, sel_off_ok;
  logic [2:0] off_sel;
  logic signed [17:0] delta;
  logic [13:0] rot;

  assign sidx = idx[IW-1:0];
  assign stat.scan_last = (idx == CW'(SLOT_COUNT - 1));
  assign stat.out_busy = out_valid && !out_ready;
  assign now_total = 11'(iw.now_hour) * 11'd60 + 11'(iw.now_minute);
  assign am = 11'(t_hour[sidx]) * 11'd60 + 11'(t_min[sidx]);
  assign today = (iw.now_weekday < 3'd7) ? 7'(7'd1 << iw.now_weekday) : 7'd0;
  assign check = iw.time_valid && (!last_valid || now_total != last_min);
  assign match = t_en[sidx] && t_hour[sidx] == iw.now_hour &&
                 t_min[sidx] == iw.now_minute && (t_days[sidx] & today) != 7'd0;

  // Rotate the day mask so bit k is weekday (now + k) mod 7.
  always_comb begin
    logic [2:0] k;
    rot = {t_days[sidx], t_days[sidx]} >> iw.now_weekday;
    off_sel = 3'd0;
    sel_off_ok = 1'b0;
    for (int o = 6; o >= 0; o--) begin
      k = 3'(o);
      if (rot[o] && !(o == 0 && am <= now_total)) begin
        off_sel = k;
        sel_off_ok = 1'b1;
      end
    end
    // Day zero excluded when already passed: fall back to day seven never
    // occurs since the loop stops at six days after, as the search does.
  end

  assign delta = 18'(off_sel) * 18'(alarm_pkg::MINUTES_PER_DAY) + 18'(am) - 18'(now_total);
  assign qok = iw.time_valid && iw.now_weekday < 3'd7 && t_en[sidx] &&
               t_days[sidx] != 7'd0 && sel_off_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_dur <= alarm_pkg::RING_DUR_RST;
      tpm <= alarm_pkg::TPM_RST;
    end else if (cfg_we) begin
      if (cfg_index == alarm_pkg::REG_RING_DUR) ring_dur <= cfg_data;
      else tpm <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        t_en[i] <= 1'b0;
        t_hour[i] <= '0;
        t_min[i] <= '0;
        t_days[i] <= '0;
        t_rep[i] <= 1'b0;
        t_snz[i] <= '0;
      end
      last_valid <= 1'b0;
      last_min <= '0;
      ring_active <= 1'b0;
      snooze_active <= 1'b0;
      snooze_spent <= 1'b0;
      cycle_valid <= 1'b0;
      cycle_slot <= '0;
      ring_elapsed <= '0;
      snooze_elapsed <= '0;
      snooze_target <= '0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        iw <= in_word;
        found <= 1'b0;
        first <= '0;
        best <= alarm_pkg::FAR_DELTA;
        nv <= 1'b0;
        nxh <= '0;
        nxm <= '0;
      end
      if (cmd.scan_clr) idx <= '0;
      if (cmd.scan_step) begin
        if (iw.opcode == alarm_pkg::OP_UPDATE && check && match) begin
          if (!t_rep[sidx]) t_en[sidx] <= 1'b0;
          if (!found) begin
            found <= 1'b1;
            first <= sidx;
          end
        end
        if (iw.opcode == alarm_pkg::OP_QUERY && qok && delta < best) begin
          best <= delta;
          nv <= 1'b1;
          nxh <= t_hour[sidx];
          nxm <= t_min[sidx];
        end
        if (!stat.scan_last) idx <= idx + CW'(1);
      end
      if (cmd.mul) begin
        if (cycle_valid && t_snz[cycle_slot] != 8'd0) snz_min <= t_snz[cycle_slot];
        else snz_min <= alarm_pkg::DEFAULT_SNOOZE;
        snz_prod <= 24'(cycle_valid && t_snz[cycle_slot] != 8'd0 ?
                        t_snz[cycle_slot] : alarm_pkg::DEFAULT_SNOOZE) * 24'(tpm);
      end
      if (cmd.decide) begin : decide_blk
        logic ra, sa, sp, cv;
        logic [IW-1:0] cs;
        logic [15:0] re;
        logic [23:0] se, st;
        logic [2:0] ev;
        logic [7:0] so;
        ra = ring_active; sa = snooze_active; sp = snooze_spent;
        cv = cycle_valid; cs = cycle_slot; re = ring_elapsed;
        se = snooze_elapsed; st = snooze_target;
        ev = alarm_pkg::EV_NONE; so = 8'd0;
        unique case (iw.opcode)
          alarm_pkg::OP_WRITE: begin
            if (32'(iw.slot) < SLOT_COUNT) begin
              t_hour[iw.slot[IW-1:0]] <= iw.alarm_hour;
              t_min[iw.slot[IW-1:0]] <= iw.alarm_minute;
              t_days[iw.slot[IW-1:0]] <= iw.days_mask;
              t_rep[iw.slot[IW-1:0]] <= iw.repeat_flag;
              t_en[iw.slot[IW-1:0]] <= iw.enable_flag;
              t_snz[iw.slot[IW-1:0]] <= iw.snooze_minutes;
              ev = alarm_pkg::EV_WRITTEN;
            end
          end
          alarm_pkg::OP_UPDATE: begin
            if (ra && re != 16'hFFFF) re = re + 16'd1;
            if (sa && se != alarm_pkg::ELAPSED_MAX) se = se + 24'd1;
            if (check) begin
              last_valid <= 1'b1;
              last_min <= now_total;
              if (found) begin
                if (!ra && !sa) begin
                  sp = 1'b0; re = '0; ra = 1'b1; cv = 1'b1; cs = first;
                  ev = alarm_pkg::EV_RING;
                end else begin
                  ra = 1'b0; sa = 1'b0; cv = 1'b0; cs = '0;
                  ev = alarm_pkg::EV_CANCEL;
                end
              end
            end
            if (ra) begin
              if (re >= ring_dur) begin
                if (!sp) begin
                  // A fresh cycle from this tick uses its own slot's snooze.
                  so = (cs == cycle_slot && cv == cycle_valid) ? snz_min :
                       ((t_snz[cs] != 8'd0) ? t_snz[cs] : alarm_pkg::DEFAULT_SNOOZE);
                  ra = 1'b0; sa = 1'b1; sp = 1'b1; se = '0;
                  st = (cs == cycle_slot && cv == cycle_valid) ? snz_prod :
                       24'(so) * 24'(tpm);
                  ev = alarm_pkg::EV_SNOOZE;
                end else begin
                  ra = 1'b0; sa = 1'b0; cv = 1'b0; cs = '0;
                  ev = alarm_pkg::EV_DISMISS;
                end
              end
            end else if (sa) begin
              if (se >= st) begin
                sa = 1'b0; re = '0; ra = 1'b1;
                ev = alarm_pkg::EV_RERING;
              end
            end
          end
          alarm_pkg::OP_DISMISS: begin
            if (ra) begin
              ra = 1'b0; sa = 1'b0; cv = 1'b0; cs = '0;
              ev = alarm_pkg::EV_DISMISS;
            end
          end
          alarm_pkg::OP_SNOOZE: begin
            if (ra) begin
              if (!sp) begin
                so = snz_min; ra = 1'b0; sa = 1'b1; sp = 1'b1; se = '0;
                st = snz_prod;
                ev = alarm_pkg::EV_SNOOZE;
              end else begin
                ra = 1'b0; sa = 1'b0; cv = 1'b0; cs = '0;
                ev = alarm_pkg::EV_DISMISS;
              end
            end
          end
          default: begin
          end
        endcase
        ring_active <= ra; snooze_active <= sa; snooze_spent <= sp;
        cycle_valid <= cv; cycle_slot <= cs; ring_elapsed <= re;
        snooze_elapsed <= se; snooze_target <= st;
        out_valid <= 1'b1;
        out_word.event_res <= ev;
        out_word.ringing <= ra;
        out_word.snoozing <= sa;
        out_word.active_slot <= cv ? 4'(cs) : 4'd8;
        out_word.snooze_length_min <= so;
        out_word.next_valid <= (iw.opcode == alarm_pkg::OP_QUERY) && nv;
        out_word.next_hour <= (iw.opcode == alarm_pkg::OP_QUERY) ? nxh : 5'd0;
        out_word.next_minute <= (iw.opcode == alarm_pkg::OP_QUERY) ? nxm : 6'd0;
      end
    end
  end

  a_snooze_excl: assert property (@(posedge clk) disable iff (rst)
    !(ring_active && snooze_active)) else $error("ring and snooze both active");
  a_cycle: assert property (@(posedge clk) disable iff (rst)
    (ring_active || snooze_active) |-> cycle_valid) else $error("cycle lost");
  a_out: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> out_valid) else $error("no result after decide");

endmodule

### rtl/alarm_slot_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Alarm slot scheduler
// Channel  Dir  Word
// in_ch    in   opcode, slot contents and current time
// out_ch   out  event, cycle flags, snooze length, next alarm
// cfg      in   ring_duration_ticks (0), ticks_per_minute (1)
// Each word passes through the scan, one slot at a time, then the snooze
// multiply and the decision. Reset is synchronous and clears the slot
// table. A result waits in the output register; the next word is taken once
// that register is free.
// ----------------------------------------------------------------------------
module alarm_slot_scheduler_unit #(
  parameter int SLOT_COUNT = alarm_pkg::SLOT_COUNT_DEF
) (
  input logic clk,
  input logic rst,
  alarm_if.sink in_ch,
  alarm_if.source out_ch,
  input logic cfg_we,
  input logic [0:0] cfg_index,
  input logic [15:0] cfg_data
);

  alarm_pkg::cmd_t cmd;
  alarm_pkg::stat_t stat;

  alarm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  alarm_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_word(in_ch.word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_word(out_ch.word), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

endmodule
